// File: hdl/lc3ie_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package lc3ie_pkg;

	localparam logic [15:0] START_PC_RESET = 16'h3000;

	localparam logic [2:0] CC_N = 3'd4;
	localparam logic [2:0] CC_Z = 3'd2;
	localparam logic [2:0] CC_P = 3'd1;

	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_BITS   = $clog2(QUEUE_DEPTH);
	localparam int QCNT_BITS   = $clog2(QUEUE_DEPTH + 1);

	// LC-3 opcodes, instruction bits 15..12
	typedef enum logic [3:0] {
		OPC_BR   = 4'h0,
		OPC_ADD  = 4'h1,
		OPC_LD   = 4'h2,
		OPC_ST   = 4'h3,
		OPC_JSR  = 4'h4,
		OPC_AND  = 4'h5,
		OPC_LDR  = 4'h6,
		OPC_STR  = 4'h7,
		OPC_RTI  = 4'h8,
		OPC_NOT  = 4'h9,
		OPC_LDI  = 4'hA,
		OPC_STI  = 4'hB,
		OPC_JMP  = 4'hC,
		OPC_RSVD = 4'hD,
		OPC_LEA  = 4'hE,
		OPC_TRAP = 4'hF
	} opcode_t;

	// Work class of one queued item, assigned by the front end
	typedef enum logic [3:0] {
		K_LOAD,
		K_ADD,
		K_AND,
		K_NOT,
		K_BR,
		K_JMP,
		K_JSR,
		K_JSRR,
		K_LD,
		K_LDI,
		K_LDR,
		K_LEA,
		K_ST,
		K_STI,
		K_STR,
		K_ILL
	} kind_t;

	typedef struct packed {
		kind_t       kind;
		logic [2:0]  dr;
		logic [2:0]  sra;
		logic [2:0]  srb;
		logic        use_imm;
		logic [15:0] imm;
		logic [15:0] addr;
	} item_t;

	typedef struct packed {
		logic [15:0] pc_after;
		logic [2:0]  cond_code;
		logic        reg_written;
		logic [2:0]  reg_index;
		logic [15:0] reg_value;
		logic        mem_written;
		logic [15:0] mem_addr;
		logic [15:0] mem_data;
		logic        illegal;
	} result_t;

	function automatic logic [2:0] cc_of(input logic [15:0] v);
		logic [2:0] cc;
		if (v == 16'd0) begin
			cc = CC_Z;
		end else if (v[15]) begin
			cc = CC_N;
		end else begin
			cc = CC_P;
		end
		return cc;
	endfunction

endpackage

`default_nettype wire

// File: hdl/lc3_instruction_execute_core.sv
// LC-3 execute core.
// Input channel (in_valid / in_stall): one beat is either a memory word
// load (op = 1, load_addr, load_data) or one instruction (op = 0, instr).
// Output channel (out_valid / out_stall): exactly one result beat per input
// beat, in order, with the PC and condition code after the item and any
// register write or store it made.
// Config channel (cfg_valid / cfg_ready, start_pc): sets the PC; write it
// only while no item is in flight. cfg_ready is always high.
// A two-entry queue sits between the decoder and the execute engine, so
// input beats are taken while the engine works or the output waits.
// Engine steps per item: register file read, then execute; LD/LDR/STI
// add a memory read step and LDI two, set by the registered register file
// read and the single read port of the word memory. The engine finishes
// one item before it takes the next from the queue.
// When out_stall is high the finished result holds in the output register
// and the engine waits; the queue then fills and in_stall rises.
// Reset clears the registers to zero, the PC to 0x3000 and the condition
// code to Z. Memory contents are undefined until loaded.
`timescale 1ns / 1ps
`default_nettype none

module lc3_instruction_execute_core #(
	parameter int ADDR_BITS = 16
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic        op,
	input  wire logic [15:0] instr,
	input  wire logic [15:0] load_addr,
	input  wire logic [15:0] load_data,
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic [15:0]      pc_after,
	output logic [2:0]       cond_code,
	output logic             reg_written,
	output logic [2:0]       reg_index,
	output logic [15:0]      reg_value,
	output logic             mem_written,
	output logic [15:0]      mem_addr,
	output logic [15:0]      mem_data,
	output logic             illegal,
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [15:0] start_pc
);
	import lc3ie_pkg::*;

	logic    head_valid;
	item_t   head_item;
	logic    pop;
	result_t res;

	assign cfg_ready = 1'b1;

	lc3ie_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.op         (op),
		.instr      (instr),
		.load_addr  (load_addr),
		.load_data  (load_data),
		.head_valid (head_valid),
		.head_item  (head_item),
		.pop        (pop)
	);

	lc3ie_back #(
		.ADDR_BITS (ADDR_BITS)
	) u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.head_valid    (head_valid),
		.head_item     (head_item),
		.pop           (pop),
		.pc_load       (cfg_valid && cfg_ready),
		.pc_load_value (start_pc),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.out_res       (res)
	);

	assign pc_after    = res.pc_after;
	assign cond_code   = res.cond_code;
	assign reg_written = res.reg_written;
	assign reg_index   = res.reg_index;
	assign reg_value   = res.reg_value;
	assign mem_written = res.mem_written;
	assign mem_addr    = res.mem_addr;
	assign mem_data    = res.mem_data;
	assign illegal     = res.illegal;

	a_pop_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> head_valid)
		else $error("pop from empty queue");

	a_cc_onehot: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> $onehot(cond_code))
		else $error("condition code not one-hot");

	a_single_write: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !(reg_written && mem_written))
		else $error("register and memory written by one item");

	a_illegal_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && illegal) |-> (!reg_written && !mem_written))
		else $error("illegal item made a write");

endmodule

`default_nettype wire

// File: hdl/lc3ie_front.sv
`timescale 1ns / 1ps
`default_nettype none

module lc3ie_front (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          in_valid,
	output logic               in_stall,
	input  wire logic          op,
	input  wire logic [15:0]   instr,
	input  wire logic [15:0]   load_addr,
	input  wire logic [15:0]   load_data,
	output logic               head_valid,
	output lc3ie_pkg::item_t   head_item,
	input  wire logic          pop
);
	import lc3ie_pkg::*;

	item_t                 dec;
	item_t                 queue_q [QUEUE_DEPTH];
	logic [QPTR_BITS-1:0]  wr_ptr_q;
	logic [QPTR_BITS-1:0]  rd_ptr_q;
	logic [QCNT_BITS-1:0]  count_q;
	logic                  push;
	logic [15:0]           sext5;
	logic [15:0]           sext6;
	logic [15:0]           sext9;
	logic [15:0]           sext11;

	assign sext5  = {{11{instr[4]}}, instr[4:0]};
	assign sext6  = {{10{instr[5]}}, instr[5:0]};
	assign sext9  = {{7{instr[8]}}, instr[8:0]};
	assign sext11 = {{5{instr[10]}}, instr[10:0]};

	always_comb begin
		dec.kind    = K_ILL;
		dec.dr      = instr[11:9];
		dec.sra     = instr[8:6];
		dec.srb     = instr[2:0];
		dec.use_imm = 1'b0;
		dec.imm     = sext9;
		dec.addr    = load_addr;
		if (op) begin
			dec.kind = K_LOAD;
			dec.imm  = load_data;
		end else begin
			case (opcode_t'(instr[15:12]))
				OPC_BR: begin
					dec.kind = K_BR;
				end
				OPC_ADD: begin
					dec.kind    = K_ADD;
					dec.use_imm = instr[5];
					dec.imm     = sext5;
				end
				OPC_AND: begin
					dec.kind    = K_AND;
					dec.use_imm = instr[5];
					dec.imm     = sext5;
				end
				OPC_NOT: begin
					dec.kind = K_NOT;
				end
				OPC_LD: begin
					dec.kind = K_LD;
				end
				OPC_LDI: begin
					dec.kind = K_LDI;
				end
				OPC_LDR: begin
					dec.kind = K_LDR;
					dec.imm  = sext6;
				end
				OPC_LEA: begin
					dec.kind = K_LEA;
				end
				OPC_ST: begin
					dec.kind = K_ST;
					dec.srb  = instr[11:9];
				end
				OPC_STI: begin
					dec.kind = K_STI;
					dec.srb  = instr[11:9];
				end
				OPC_STR: begin
					dec.kind = K_STR;
					dec.srb  = instr[11:9];
					dec.imm  = sext6;
				end
				OPC_JMP: begin
					dec.kind = K_JMP;
				end
				OPC_JSR: begin
					dec.kind = instr[11] ? K_JSR : K_JSRR;
					dec.imm  = sext11;
				end
				default: begin
					dec.kind = K_ILL;
				end
			endcase
		end
	end

	assign in_stall   = (count_q == QCNT_BITS'(QUEUE_DEPTH));
	assign push       = in_valid && !in_stall;
	assign head_valid = (count_q != '0);
	assign head_item  = queue_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			queue_q[wr_ptr_q] <= dec;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

`default_nettype wire

// File: hdl/lc3ie_back.sv
`timescale 1ns / 1ps
`default_nettype none

module lc3ie_back #(
	parameter int ADDR_BITS = 16
) (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           head_valid,
	input  wire lc3ie_pkg::item_t head_item,
	output logic                pop,
	input  wire logic           pc_load,
	input  wire logic [15:0]    pc_load_value,
	output logic                out_valid,
	input  wire logic           out_stall,
	output lc3ie_pkg::result_t  out_res
);
	import lc3ie_pkg::*;

	localparam int MEM_WORDS = 1 << ADDR_BITS;
	localparam logic [15:0] ADDR_MASK = 16'((32'd1 << ADDR_BITS) - 32'd1);

	typedef enum logic [1:0] {
		ST_RD,
		ST_EX,
		ST_MEM,
		ST_IND
	} state_t;

	state_t                 state_q;
	state_t                 state_d;
	logic [15:0]            pc_q;
	logic [2:0]             cc_q;
	logic [15:0]            rf_q [8];
	logic [15:0]            ra_q;
	logic [15:0]            rb_q;
	logic                   out_valid_q;
	result_t                out_q;

	logic [15:0]            mem_q [MEM_WORDS];
	logic [15:0]            mem_rdata_q;
	logic                   mem_re;
	logic [ADDR_BITS-1:0]   mem_raddr;
	logic                   mem_we;
	logic [ADDR_BITS-1:0]   mem_waddr;
	logic [15:0]            mem_wdata;

	logic                   emit;
	logic                   emit_ok;
	logic                   commit;
	result_t                res;
	logic [15:0]            opb;
	logic [15:0]            pc_inc;
	logic [15:0]            pc_rel;
	logic [15:0]            base_off;
	logic [15:0]            rval;

	assign emit_ok  = !out_valid_q || !out_stall;
	assign commit   = emit && emit_ok;
	assign pop      = commit;
	assign opb      = head_item.use_imm ? head_item.imm : rb_q;
	assign pc_inc   = pc_q + 16'd1;
	assign pc_rel   = pc_inc + head_item.imm;
	assign base_off = ra_q + head_item.imm;

	always_comb begin
		state_d         = state_q;
		emit            = 1'b0;
		mem_re          = 1'b0;
		mem_raddr       = pc_rel[ADDR_BITS-1:0];
		mem_we          = 1'b0;
		mem_waddr       = pc_rel[ADDR_BITS-1:0];
		mem_wdata       = rb_q;
		rval            = 16'd0;
		res             = '0;
		res.pc_after    = pc_inc;
		res.cond_code   = cc_q;
		case (state_q)
			ST_RD: begin
				if (head_valid) begin
					state_d = ST_EX;
				end
			end
			ST_EX: begin
				emit = 1'b1;
				case (head_item.kind)
					K_LOAD: begin
						res.pc_after = pc_q;
						mem_we       = 1'b1;
						mem_waddr    = head_item.addr[ADDR_BITS-1:0];
						mem_wdata    = head_item.imm;
					end
					K_ADD, K_AND, K_NOT, K_LEA: begin
						case (head_item.kind)
							K_ADD:   rval = ra_q + opb;
							K_AND:   rval = ra_q & opb;
							K_NOT:   rval = ~ra_q;
							default: rval = pc_rel;
						endcase
						res.reg_written = 1'b1;
						res.reg_index   = head_item.dr;
						res.reg_value   = rval;
						res.cond_code   = cc_of(rval);
					end
					K_BR: begin
						if ((head_item.dr & cc_q) != 3'd0) begin
							res.pc_after = pc_rel;
						end
					end
					K_JMP: begin
						res.pc_after = ra_q;
					end
					K_JSR, K_JSRR: begin
						res.pc_after    = (head_item.kind == K_JSR) ? pc_rel : ra_q;
						res.reg_written = 1'b1;
						res.reg_index   = 3'd7;
						res.reg_value   = pc_inc;
					end
					K_ST, K_STR: begin
						mem_we          = 1'b1;
						mem_waddr       = (head_item.kind == K_ST) ?
							pc_rel[ADDR_BITS-1:0] : base_off[ADDR_BITS-1:0];
						res.mem_written = 1'b1;
						res.mem_addr    = ((head_item.kind == K_ST) ? pc_rel : base_off)
							& ADDR_MASK;
						res.mem_data    = rb_q;
					end
					K_LD, K_LDI, K_STI, K_LDR: begin
						// issue the first read, no result yet
						emit      = 1'b0;
						mem_re    = 1'b1;
						mem_raddr = (head_item.kind == K_LDR) ?
							base_off[ADDR_BITS-1:0] : pc_rel[ADDR_BITS-1:0];
						state_d   = ST_MEM;
					end
					default: begin
						res.illegal = 1'b1;
					end
				endcase
			end
			ST_MEM: begin
				case (head_item.kind)
					K_LDI: begin
						mem_re    = 1'b1;
						mem_raddr = mem_rdata_q[ADDR_BITS-1:0];
						state_d   = ST_IND;
					end
					K_STI: begin
						emit            = 1'b1;
						mem_we          = 1'b1;
						mem_waddr       = mem_rdata_q[ADDR_BITS-1:0];
						res.mem_written = 1'b1;
						res.mem_addr    = mem_rdata_q & ADDR_MASK;
						res.mem_data    = rb_q;
					end
					default: begin
						emit            = 1'b1;
						res.reg_written = 1'b1;
						res.reg_index   = head_item.dr;
						res.reg_value   = mem_rdata_q;
						res.cond_code   = cc_of(mem_rdata_q);
					end
				endcase
			end
			ST_IND: begin
				emit            = 1'b1;
				res.reg_written = 1'b1;
				res.reg_index   = head_item.dr;
				res.reg_value   = mem_rdata_q;
				res.cond_code   = cc_of(mem_rdata_q);
			end
			default: begin
				state_d = ST_RD;
			end
		endcase
		if (commit) begin
			state_d = ST_RD;
		end
	end

	// Reads hold their data while the result waits on the output register
	always_ff @(posedge clk) begin
		if (mem_we && commit) begin
			mem_q[mem_waddr] <= mem_wdata;
		end
		if (mem_re) begin
			mem_rdata_q <= mem_q[mem_raddr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_RD;
			pc_q        <= START_PC_RESET;
			cc_q        <= CC_Z;
			out_valid_q <= 1'b0;
			out_q       <= '0;
			ra_q        <= '0;
			rb_q        <= '0;
			for (int i = 0; i < 8; i++) begin
				rf_q[i] <= '0;
			end
		end else begin
			state_q <= state_d;
			if (state_q == ST_RD && head_valid) begin
				ra_q <= rf_q[head_item.sra];
				rb_q <= rf_q[head_item.srb];
			end
			if (commit) begin
				pc_q        <= res.pc_after;
				cc_q        <= res.cond_code;
				out_q       <= res;
				out_valid_q <= 1'b1;
				if (res.reg_written) begin
					rf_q[res.reg_index] <= res.reg_value;
				end
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
			if (pc_load) begin
				pc_q <= pc_load_value;
			end
		end
	end

	assign out_valid = out_valid_q;
	assign out_res   = out_q;

endmodule

`default_nettype wire

// File: dv/testbench.sv
`timescale 1ns / 1ps

module testbench;
	import lc3ie_pkg::*;

	localparam int ADDR_BITS = 16;
	localparam int MEM_WORDS = 1 << ADDR_BITS;
	localparam logic [15:0] MEM_MASK = 16'((32'd1 << ADDR_BITS) - 1);

	localparam logic ITEM_EXEC = 1'b0;
	localparam logic ITEM_LOAD = 1'b1;

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_stall;
	logic        op;
	logic [15:0] instr;
	logic [15:0] load_addr;
	logic [15:0] load_data;
	logic        out_valid;
	logic        out_stall;
	logic [15:0] pc_after;
	logic [2:0]  cond_code;
	logic        reg_written;
	logic [2:0]  reg_index;
	logic [15:0] reg_value;
	logic        mem_written;
	logic [15:0] mem_addr;
	logic [15:0] mem_data;
	logic        illegal;
	logic        cfg_valid;
	logic        cfg_ready;
	logic [15:0] start_pc;

	lc3_instruction_execute_core #(
		.ADDR_BITS(ADDR_BITS)
	) dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.op         (op),
		.instr      (instr),
		.load_addr  (load_addr),
		.load_data  (load_data),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.pc_after   (pc_after),
		.cond_code  (cond_code),
		.reg_written(reg_written),
		.reg_index  (reg_index),
		.reg_value  (reg_value),
		.mem_written(mem_written),
		.mem_addr   (mem_addr),
		.mem_data   (mem_data),
		.illegal    (illegal),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.start_pc   (start_pc)
	);

	// Architectural state as the core should hold it
	logic [15:0] gpr_file [0:7];
	logic [15:0] prog_ctr;
	logic [2:0]  cond_flags;
	logic [15:0] mem_word [0:MEM_WORDS-1];
	bit          mem_known [0:MEM_WORDS-1];

	result_t results_due [$];
	int      error_count;
	bit      quiet;
	bit      hold_output;

	initial clk = 1'b0;
	always #5 clk = ~clk;

	function automatic logic [15:0] field_sext(input logic [15:0] v, input int bits);
		logic [15:0] m;
		m = 16'((32'd1 << bits) - 1);
		return v[bits-1] ? (v | ~m) : (v & m);
	endfunction

	function automatic logic [2:0] flags_for(input logic [15:0] v);
		if (v == 16'd0)
			return CC_Z;
		return v[15] ? CC_N : CC_P;
	endfunction

	function automatic logic [15:0] read_word(input logic [15:0] a);
		return mem_word[a & MEM_MASK];
	endfunction

	function automatic result_t execute_lc3(input logic is_load, input logic [15:0] ins,
			input logic [15:0] a, input logic [15:0] d);
		result_t     r;
		opcode_t     opc;
		logic [2:0]  dr;
		logic [2:0]  sr1;
		logic [2:0]  sr2;
		logic [15:0] off9;
		logic [15:0] pc_inc;
		r = '0;
		if (is_load == ITEM_LOAD) begin
			mem_word[a & MEM_MASK] = d;
			mem_known[a & MEM_MASK] = 1'b1;
		end else begin
			opc = opcode_t'(ins[15:12]);
			dr = ins[11:9];
			sr1 = ins[8:6];
			sr2 = ins[2:0];
			off9 = field_sext(ins, 9);
			prog_ctr = prog_ctr + 16'd1;
			pc_inc = prog_ctr;
			case (opc)
				OPC_ADD: begin
					r.reg_written = 1'b1;
					r.reg_index = dr;
					r.reg_value = gpr_file[sr1] +
						(ins[5] ? field_sext(ins, 5) : gpr_file[sr2]);
				end
				OPC_AND: begin
					r.reg_written = 1'b1;
					r.reg_index = dr;
					r.reg_value = gpr_file[sr1] &
						(ins[5] ? field_sext(ins, 5) : gpr_file[sr2]);
				end
				OPC_NOT: begin
					r.reg_written = 1'b1;
					r.reg_index = dr;
					r.reg_value = ~gpr_file[sr1];
				end
				OPC_BR: begin
					if ((dr & cond_flags) != 3'd0)
						prog_ctr = pc_inc + off9;
				end
				OPC_JMP: prog_ctr = gpr_file[sr1];
				OPC_JSR: begin
					// take the base before R7 is overwritten
					if (ins[11])
						prog_ctr = pc_inc + field_sext(ins, 11);
					else
						prog_ctr = gpr_file[sr1];
					gpr_file[7] = pc_inc;
					r.reg_written = 1'b1;
					r.reg_index = 3'd7;
					r.reg_value = pc_inc;
				end
				OPC_LD: begin
					r.reg_written = 1'b1;
					r.reg_index = dr;
					r.reg_value = read_word(pc_inc + off9);
				end
				OPC_LDI: begin
					r.reg_written = 1'b1;
					r.reg_index = dr;
					r.reg_value = read_word(read_word(pc_inc + off9));
				end
				OPC_LDR: begin
					r.reg_written = 1'b1;
					r.reg_index = dr;
					r.reg_value = read_word(gpr_file[sr1] + field_sext(ins, 6));
				end
				OPC_LEA: begin
					r.reg_written = 1'b1;
					r.reg_index = dr;
					r.reg_value = pc_inc + off9;
				end
				OPC_ST: begin
					r.mem_written = 1'b1;
					r.mem_addr = (pc_inc + off9) & MEM_MASK;
					r.mem_data = gpr_file[dr];
				end
				OPC_STI: begin
					r.mem_written = 1'b1;
					r.mem_addr = read_word(pc_inc + off9) & MEM_MASK;
					r.mem_data = gpr_file[dr];
				end
				OPC_STR: begin
					r.mem_written = 1'b1;
					r.mem_addr = (gpr_file[sr1] + field_sext(ins, 6)) & MEM_MASK;
					r.mem_data = gpr_file[dr];
				end
				default: r.illegal = 1'b1;
			endcase
			if (r.reg_written && opc != OPC_JSR) begin
				gpr_file[r.reg_index] = r.reg_value;
				cond_flags = flags_for(r.reg_value);
			end
			if (r.mem_written) begin
				mem_word[r.mem_addr] = r.mem_data;
				mem_known[r.mem_addr] = 1'b1;
			end
		end
		r.pc_after = prog_ctr;
		r.cond_code = cond_flags;
		return r;
	endfunction

	// Offer one beat, hold it until taken, then log what it must produce
	task automatic send_item(input logic is_load, input logic [15:0] ins,
			input logic [15:0] a, input logic [15:0] d);
		int gap;
		if (!quiet && $urandom_range(0, 5) == 0) begin
			gap = $urandom_range(1, 3);
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		op <= is_load;
		instr <= ins;
		load_addr <= a;
		load_data <= d;
		do @(posedge clk); while (in_stall);
		results_due.push_back(execute_lc3(is_load, ins, a, d));
	endtask

	task automatic make_known(input logic [15:0] a);
		if (!mem_known[a & MEM_MASK])
			send_item(ITEM_LOAD, 16'($urandom), a, 16'($urandom));
	endtask

	// Preload every not yet known word the instruction will read, then issue it
	task automatic run_instr(input logic [15:0] ins);
		opcode_t     opc;
		logic [15:0] ea;
		opc = opcode_t'(ins[15:12]);
		ea = prog_ctr + 16'd1 + field_sext(ins, 9);
		case (opc)
			OPC_LD, OPC_STI: make_known(ea);
			OPC_LDI: begin
				make_known(ea);
				make_known(read_word(ea));
			end
			OPC_LDR: make_known(gpr_file[ins[8:6]] + field_sext(ins, 6));
			default: ;
		endcase
		send_item(ITEM_EXEC, ins, 16'($urandom), 16'($urandom));
	endtask

	task automatic random_item();
		logic [15:0] a;
		if ($urandom_range(0, 9) == 0) begin
			a = $urandom_range(0, 1) ? 16'($urandom) : prog_ctr + 16'($urandom_range(0, 511)) - 16'd256;
			send_item(ITEM_LOAD, 16'($urandom), a, 16'($urandom));
		end else begin
			run_instr(16'($urandom));
		end
	endtask

	task automatic drain_results();
		in_valid <= 1'b0;
		while (results_due.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic write_start_pc(input logic [15:0] v);
		drain_results();
		cfg_valid <= 1'b1;
		start_pc <= v;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		prog_ctr = v;
	endtask

	task automatic test_directed();
		send_item(ITEM_LOAD, 16'h0000, 16'hFFFF, 16'hFFFF);
		send_item(ITEM_LOAD, 16'hFFFF, 16'h0000, 16'h0000);
		run_instr(16'h0402);    // BRz taken from the reset flags
		run_instr(16'h1270);    // ADD R1,R1,#-16
		run_instr(16'h142F);    // ADD R2,R0,#15
		run_instr(16'h1642);    // ADD R3,R1,R2
		run_instr(16'h58E0);    // AND R4,R3,#0
		run_instr(16'h5AC2);    // AND R5,R3,R2
		run_instr(16'h9D3F);    // NOT R6,R4, low bits set
		run_instr(16'h01FF);    // BR with no flags selected
		run_instr(16'h0900);    // BRn back by 256
		run_instr(16'h02FF);    // BRp not taken
		run_instr(16'hE0FF);    // LEA R0,#255
		run_instr(16'h3600);    // ST R3,#0
		run_instr(16'h23FF);    // LD R1,#-1 reads the word just stored
		run_instr(16'hA4FF);    // LDI R2,#255
		run_instr(16'h6A20);    // LDR R5,R0,#-32
		run_instr(16'h7C1F);    // STR R6,R0,#31
		run_instr(16'hB300);    // STI R1,#-256
		run_instr(16'h4BFF);    // JSR +1023
		run_instr(16'h4C00);    // JSR -1024
		run_instr(16'h41C0);    // JSRR R7
		run_instr(16'hCEBF);    // JMP R2, ignored bits set
		run_instr(16'hC1C0);    // RET
		run_instr(16'h8000);    // RTI
		run_instr(16'hDFFF);    // reserved
		run_instr(16'hF025);    // TRAP
	endtask

	task automatic test_start_pc_extremes();
		write_start_pc(16'h0000);
		repeat (20) random_item();
		// PC wraps to zero on the first fetch
		write_start_pc(16'hFFFF);
		run_instr(16'h0000);
		repeat (20) random_item();
		write_start_pc(16'($urandom));
		repeat (20) random_item();
	endtask

	task automatic test_backpressure();
		hold_output = 1'b1;
		repeat (30) random_item();
	endtask

	task automatic test_random();
		for (int phase = 0; phase < 5; phase++) begin
			write_start_pc(16'($urandom));
			if (phase == 4)
				quiet = 1'b1;
			repeat (160) random_item();
		end
	endtask

	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		op = ITEM_EXEC;
		instr = 16'h0000;
		load_addr = 16'h0000;
		load_data = 16'h0000;
		cfg_valid = 1'b0;
		start_pc = START_PC_RESET;
		error_count = 0;
		quiet = 1'b0;
		hold_output = 1'b0;
		for (int i = 0; i < 8; i++)
			gpr_file[i] = 16'h0000;
		prog_ctr = START_PC_RESET;
		cond_flags = CC_Z;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed();
		test_start_pc_extremes();
		test_backpressure();
		test_random();

		drain_results();
		repeat (10) @(posedge clk);
		if (error_count == 0)
			$display("testbench: PASS");
		else
			$display("testbench: FAIL");
		$finish;
	end

	// Output side: short random stalls, one long hold-off on request
	initial begin
		out_stall = 1'b0;
		while (!arst_n) @(posedge clk);
		forever begin
			@(posedge clk);
			if (hold_output) begin
				out_stall <= 1'b1;
				repeat (60) @(posedge clk);
				out_stall <= 1'b0;
				hold_output = 1'b0;
			end else if (!quiet && $urandom_range(0, 6) == 0) begin
				out_stall <= 1'b1;
				repeat ($urandom_range(1, 3)) @(posedge clk);
				out_stall <= 1'b0;
			end
		end
	end

	task automatic check_field(input string name, input logic [15:0] want,
			input logic [15:0] got);
		if (got !== want) begin
			$display("%0t: %s expected %h actual %h", $time, name, want, got);
			error_count++;
		end
	endtask

	always @(posedge clk) begin : check_results
		result_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (results_due.size() == 0) begin
				$display("%0t: result beat with nothing expected, pc_after %h",
					$time, pc_after);
				error_count++;
			end else begin
				want = results_due.pop_front();
				check_field("pc_after", want.pc_after, pc_after);
				check_field("cond_code", 16'(want.cond_code), 16'(cond_code));
				check_field("reg_written", 16'(want.reg_written), 16'(reg_written));
				check_field("reg_index", 16'(want.reg_index), 16'(reg_index));
				check_field("reg_value", want.reg_value, reg_value);
				check_field("mem_written", 16'(want.mem_written), 16'(mem_written));
				check_field("mem_addr", want.mem_addr, mem_addr);
				check_field("mem_data", want.mem_data, mem_data);
				check_field("illegal", 16'(want.illegal), 16'(illegal));
			end
		end
	end

	initial begin
		#2000000;
		$display("testbench: FAIL");
		$finish;
	end

endmodule
